FILE: design/tsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tone sample generator package
// Shared widths, codes, fixed-point constants and the controller to datapath
// command and status types.
// ----------------------------------------------------------------------------
package tsg_pkg;

	// Design constants.
	localparam int ANGLE_BITS    = 16;
	localparam int POSITION_BITS = 31;

	// Field and register widths.
	localparam int FREQ_W    = 20;
	localparam int RATE_W    = 18;
	localparam int TOTAL_W   = 31;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 2;
	localparam int CMD_W     = 2;
	localparam int OFFSET_W  = 32;
	localparam int SAMPLE_W  = 16;
	localparam int STATUS_W  = 2;
	localparam int POS_OUT_W = 31;

	// Derived widths.
	localparam int POS_W     = POSITION_BITS;
	localparam int END_W     = (POS_W > TOTAL_W) ? POS_W : TOTAL_W;
	localparam int SEEK_BASE = (END_W > OFFSET_W) ? END_W : OFFSET_W;
	localparam int SEEK_W    = SEEK_BASE + 2;
	localparam int PROD_W    = FREQ_W + POS_W;
	localparam int DIV_CNT_W = $clog2(PROD_W + 1);
	localparam int X_W       = ANGLE_BITS - 1;
	localparam int X_SHIFT   = 62 - ANGLE_BITS;

	// Fixed-point arithmetic widths.
	localparam int QW        = 64;
	localparam int PW        = 2 * QW;
	localparam int QUO_W     = PW - 66;
	localparam int RND_W     = 80;
	localparam int MAG_W     = RND_W - 60;
	localparam int TERMS     = 12;
	localparam int K_W       = 4;
	localparam int TDIV_W    = 10;

	// Types.
	typedef logic [QW-1:0]           q60_t;
	typedef logic [POS_W-1:0]        pos_t;
	typedef logic [END_W-1:0]        end_t;
	typedef logic signed [SEEK_W-1:0] seek_t;
	typedef logic [POS_OUT_W-1:0]    pos_out_t;
	typedef logic [MAG_W-1:0]        mag_t;
	typedef logic [RND_W-1:0]        rnd_t;
	typedef logic [PROD_W-1:0]       prod_t;
	typedef logic [DIV_CNT_W-1:0]    div_cnt_t;
	typedef logic [K_W-1:0]          k_t;

	// Fixed-point constants.
	localparam q60_t Q60_HALF_PI = 64'h1921FB54442D1847;
	localparam q60_t SCALE_MAX   = 64'd32767;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
	localparam rnd_t ROUND_HALF  = rnd_t'(1) << 59;
	localparam pos_t POS_MAX     = '1;
	localparam logic [X_W-1:0] QUARTER = X_W'(1) << (ANGLE_BITS - 2);
	localparam logic [66:0] Q66_ONE = 67'd1 << 66;

	// Reciprocals floor(2^66 / d) of the Taylor series divisors.
	localparam q60_t RECIP_1  = q60_t'(Q66_ONE / 67'd6);
	localparam q60_t RECIP_2  = q60_t'(Q66_ONE / 67'd20);
	localparam q60_t RECIP_3  = q60_t'(Q66_ONE / 67'd42);
	localparam q60_t RECIP_4  = q60_t'(Q66_ONE / 67'd72);
	localparam q60_t RECIP_5  = q60_t'(Q66_ONE / 67'd110);
	localparam q60_t RECIP_6  = q60_t'(Q66_ONE / 67'd156);
	localparam q60_t RECIP_7  = q60_t'(Q66_ONE / 67'd210);
	localparam q60_t RECIP_8  = q60_t'(Q66_ONE / 67'd272);
	localparam q60_t RECIP_9  = q60_t'(Q66_ONE / 67'd342);
	localparam q60_t RECIP_10 = q60_t'(Q66_ONE / 67'd420);
	localparam q60_t RECIP_11 = q60_t'(Q66_ONE / 67'd506);
	localparam q60_t RECIP_12 = q60_t'(Q66_ONE / 67'd600);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FREQ  = 2'd0,
		CFG_RATE  = 2'd1,
		CFG_TOTAL = 2'd2
	} cfg_idx_t;

	// Input commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_READ     = 2'd0,
		CMD_SEEK_ABS = 2'd1,
		CMD_SEEK_REL = 2'd2,
		CMD_SEEK_END = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_SAMPLE      = 2'd0,
		STATUS_END         = 2'd1,
		STATUS_SEEK_DONE   = 2'd2,
		STATUS_SEEK_REJECT = 2'd3
	} status_t;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_SEEK,
		OP_END,
		OP_MUL_FP,
		OP_MOD,
		OP_ANGLE,
		OP_TAKE_ANGLE,
		OP_ZERO_ANGLE,
		OP_ARG,
		OP_SQUARE,
		OP_TERM_FIRST,
		OP_RECIP,
		OP_QD,
		OP_CORR,
		OP_ACC,
		OP_SCALE,
		OP_FINISH,
		OP_PUSH
	} dp_op_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WAIT_FP,
		S_WAIT_MOD,
		S_WAIT_ANG,
		S_ARG,
		S_WAIT_ARG,
		S_WAIT_SQ,
		S_WAIT_TM,
		S_WAIT_RC,
		S_WAIT_QD,
		S_ACC,
		S_SCALE,
		S_WAIT_SC,
		S_PUSH
	} state_t;

	// Datapath status seen by the controller.
	typedef struct packed {
		logic is_read;
		logic at_end;
		logic rate_zero;
		logic mul_done;
		logic div_done;
		logic last_term;
		logic out_free;
	} dp_status_t;

	// Divisor (2k)(2k+1) of Taylor term k.
	function automatic logic [TDIV_W-1:0] term_div(input k_t k);
		logic [TDIV_W-1:0] d;
		case (k)
			4'd1:    d = 10'd6;
			4'd2:    d = 10'd20;
			4'd3:    d = 10'd42;
			4'd4:    d = 10'd72;
			4'd5:    d = 10'd110;
			4'd6:    d = 10'd156;
			4'd7:    d = 10'd210;
			4'd8:    d = 10'd272;
			4'd9:    d = 10'd342;
			4'd10:   d = 10'd420;
			4'd11:   d = 10'd506;
			4'd12:   d = 10'd600;
			default: d = 10'd6;
		endcase
		return d;
	endfunction

	// Reciprocal of the divisor of Taylor term k.
	function automatic q60_t term_recip(input k_t k);
		q60_t r;
		case (k)
			4'd1:    r = RECIP_1;
			4'd2:    r = RECIP_2;
			4'd3:    r = RECIP_3;
			4'd4:    r = RECIP_4;
			4'd5:    r = RECIP_5;
			4'd6:    r = RECIP_6;
			4'd7:    r = RECIP_7;
			4'd8:    r = RECIP_8;
			4'd9:    r = RECIP_9;
			4'd10:   r = RECIP_10;
			4'd11:   r = RECIP_11;
			4'd12:   r = RECIP_12;
			default: r = RECIP_1;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/tsg_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tone sample generator multiplier
// 64 by 64 bit unsigned multiplier built from one 32 by 32 bit multiplier,
// accumulating the four partial products in turn.
// ----------------------------------------------------------------------------
module tsg_mul (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire tsg_pkg::q60_t           a,
	input  wire tsg_pkg::q60_t           b,
	output logic [tsg_pkg::PW-1:0]       prod,
	output logic                         done
);

	logic [tsg_pkg::QW-1:0] a_q;
	logic [tsg_pkg::QW-1:0] b_q;
	logic [tsg_pkg::PW-1:0] acc_q;
	logic [1:0]             step_q;
	logic                   busy_q;
	logic                   done_q;
	logic [31:0]            half_a;
	logic [31:0]            half_b;
	logic [63:0]            pp;
	logic [tsg_pkg::PW-1:0] addend;

	// Select the operand halves for this step and align the partial product.
	always_comb begin
		half_a = step_q[1] ? a_q[63:32] : a_q[31:0];
		half_b = step_q[0] ? b_q[63:32] : b_q[31:0];
		pp     = {32'd0, half_a} * {32'd0, half_b};
		case (step_q)
			2'd0:    addend = {64'd0, pp};
			2'd1:    addend = {32'd0, pp, 32'd0};
			2'd2:    addend = {32'd0, pp, 32'd0};
			2'd3:    addend = {pp, 64'd0};
			default: addend = '0;
		endcase
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and accumulator registers.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + addend;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule
`default_nettype wire

FILE: design/tsg_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tone sample generator divider
// Restoring divider by the sample rate, one quotient bit per cycle; serves
// both the phase residue and the angle scaling.
// ----------------------------------------------------------------------------
module tsg_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [tsg_pkg::RATE_W-1:0]    init_rem,
	input  wire tsg_pkg::prod_t                dividend,
	input  wire tsg_pkg::div_cnt_t             iters,
	input  wire logic [tsg_pkg::RATE_W-1:0]    divisor,
	output logic [tsg_pkg::RATE_W-1:0]         rem,
	output logic [tsg_pkg::ANGLE_BITS-1:0]     quo,
	output logic                               done
);

	logic [tsg_pkg::RATE_W-1:0]     rem_q;
	tsg_pkg::prod_t                 dvd_q;
	logic [tsg_pkg::ANGLE_BITS-1:0] quo_q;
	tsg_pkg::div_cnt_t              cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [tsg_pkg::RATE_W:0]       shifted;
	logic [tsg_pkg::RATE_W:0]       diff;
	logic                           ge;
	logic [tsg_pkg::RATE_W-1:0]     rem_next;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		shifted  = {rem_q, dvd_q[tsg_pkg::PROD_W-1]};
		diff     = shifted - {1'b0, divisor};
		ge       = (shifted >= {1'b0, divisor});
		rem_next = ge ? diff[tsg_pkg::RATE_W-1:0] : shifted[tsg_pkg::RATE_W-1:0];
	end

	// Iteration counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - tsg_pkg::div_cnt_t'(1);
				if (cnt_q == tsg_pkg::div_cnt_t'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, dividend and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= init_rem;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[tsg_pkg::ANGLE_BITS-2:0], ge};
		end
	end

	assign rem  = rem_q;
	assign quo  = quo_q;
	assign done = done_q;

endmodule
`default_nettype wire

FILE: design/tsg_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tone sample generator datapath
// Configuration, position and working registers, the shared multiplier and
// divider, the seek arithmetic and the output word register.
// ----------------------------------------------------------------------------
module tsg_dpath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire tsg_pkg::dp_op_t                  op,
	input  wire logic [tsg_pkg::CMD_W-1:0]        in_cmd,
	input  wire logic [tsg_pkg::OFFSET_W-1:0]     in_offset,
	input  wire logic                             cfg_we,
	input  wire logic [tsg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tsg_pkg::CFG_W-1:0]        cfg_wdata,
	input  wire logic                             out_ready,
	output tsg_pkg::dp_status_t                   status,
	output logic                                  out_valid,
	output logic [tsg_pkg::SAMPLE_W-1:0]          out_sample,
	output logic [tsg_pkg::STATUS_W-1:0]          out_status,
	output logic [tsg_pkg::POS_OUT_W-1:0]         out_position
);

	// Configuration and position.
	logic [tsg_pkg::FREQ_W-1:0]  freq_q;
	logic [tsg_pkg::RATE_W-1:0]  rate_q;
	logic [tsg_pkg::TOTAL_W-1:0] total_q;
	tsg_pkg::pos_t               pos_q;

	// Latched item.
	tsg_pkg::cmd_t                    cmd_q;
	logic signed [tsg_pkg::OFFSET_W-1:0] off_q;

	// Working registers.
	logic [tsg_pkg::ANGLE_BITS-1:0] angle_q;
	tsg_pkg::q60_t                  term_q;
	tsg_pkg::q60_t                  x2_q;
	tsg_pkg::q60_t                  sum_q;
	tsg_pkg::q60_t                  t_q;
	logic [tsg_pkg::QUO_W-1:0]      q_q;
	tsg_pkg::k_t                    k_q;
	logic [tsg_pkg::SAMPLE_W-1:0]   res_sample_q;
	tsg_pkg::status_t               res_status_q;

	// Output word register.
	logic                           out_valid_q;
	logic [tsg_pkg::SAMPLE_W-1:0]   out_sample_q;
	tsg_pkg::status_t               out_status_q;
	tsg_pkg::pos_out_t              out_pos_q;

	// Shared units.
	logic                           mul_start;
	tsg_pkg::q60_t                  mul_a;
	tsg_pkg::q60_t                  mul_b;
	logic [tsg_pkg::PW-1:0]         prod;
	logic                           mul_done;
	logic                           div_start;
	logic [tsg_pkg::RATE_W-1:0]     div_init;
	tsg_pkg::prod_t                 div_dvd;
	tsg_pkg::div_cnt_t              div_iters;
	logic [tsg_pkg::RATE_W-1:0]     div_rem;
	logic [tsg_pkg::ANGLE_BITS-1:0] div_quo;
	logic                           div_done;

	// Combinational helpers.
	tsg_pkg::end_t                  end_w;
	tsg_pkg::seek_t                 seek_base;
	tsg_pkg::seek_t                 target;
	logic                           reject;
	tsg_pkg::q60_t                  q60;
	logic [1:0]                     quad;
	logic [tsg_pkg::X_W-1:0]        x;
	tsg_pkg::q60_t                  x_scaled;
	tsg_pkg::q60_t                  corr_rem;
	logic                           corr_up;
	tsg_pkg::q60_t                  term_fixed;
	tsg_pkg::rnd_t                  rounded;
	tsg_pkg::mag_t                  mag_full;
	logic [tsg_pkg::SAMPLE_W-1:0]   mag;
	logic [tsg_pkg::SAMPLE_W-1:0]   sample_val;
	logic                           last_term;

	tsg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod),
		.done   (mul_done)
	);

	tsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.init_rem (div_init),
		.dividend (div_dvd),
		.iters    (div_iters),
		.divisor  (rate_q),
		.rem      (div_rem),
		.quo      (div_quo),
		.done     (div_done)
	);

	// End of tone, limited so that the position register never wraps.
	always_comb begin
		if (tsg_pkg::end_t'(total_q) < tsg_pkg::end_t'(tsg_pkg::POS_MAX)) begin
			end_w = tsg_pkg::end_t'(total_q);
		end else begin
			end_w = tsg_pkg::end_t'(tsg_pkg::POS_MAX);
		end
	end

	// Seek target and range check.
	always_comb begin
		case (cmd_q)
			tsg_pkg::CMD_SEEK_REL: seek_base = tsg_pkg::seek_t'(pos_q);
			tsg_pkg::CMD_SEEK_END: seek_base = tsg_pkg::seek_t'(total_q);
			default:               seek_base = '0;
		endcase
		target = seek_base + tsg_pkg::seek_t'(off_q);
		reject = target[tsg_pkg::SEEK_W-1] || (target > tsg_pkg::seek_t'(end_w));
	end

	// Quarter-wave folding of the angle and the Q60 view of the product.
	always_comb begin
		q60      = prod[123:60];
		quad     = angle_q[tsg_pkg::ANGLE_BITS-1 -: 2];
		if (quad[0]) begin
			x = tsg_pkg::QUARTER - {1'b0, angle_q[tsg_pkg::ANGLE_BITS-3:0]};
		end else begin
			x = {1'b0, angle_q[tsg_pkg::ANGLE_BITS-3:0]};
		end
		x_scaled = tsg_pkg::q60_t'(x) << tsg_pkg::X_SHIFT;
	end

	// Correction of the reciprocal quotient by at most one.
	always_comb begin
		corr_rem   = t_q - prod[tsg_pkg::QW-1:0];
		corr_up    = (corr_rem >= tsg_pkg::q60_t'(tsg_pkg::term_div(k_q)));
		term_fixed = tsg_pkg::q60_t'(q_q) + tsg_pkg::q60_t'(corr_up);
		last_term  = (k_q == tsg_pkg::k_t'(tsg_pkg::TERMS));
	end

	// Scaling to Q1.15 with rounding, limiting and the sign of the half-wave.
	always_comb begin
		rounded  = prod[tsg_pkg::RND_W-1:0] + tsg_pkg::ROUND_HALF;
		mag_full = rounded[tsg_pkg::RND_W-1:60];
		if (mag_full > tsg_pkg::mag_t'(tsg_pkg::SAMPLE_MAX)) begin
			mag = tsg_pkg::SAMPLE_MAX;
		end else begin
			mag = mag_full[tsg_pkg::SAMPLE_W-1:0];
		end
		sample_val = quad[1] ? (tsg_pkg::SAMPLE_W'(0) - mag) : mag;
	end

	// Operand selection for the shared units.
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_init  = '0;
		div_dvd   = '0;
		div_iters = '0;
		case (op)
			tsg_pkg::OP_MUL_FP: begin
				mul_start = 1'b1;
				mul_a     = tsg_pkg::q60_t'(freq_q);
				mul_b     = tsg_pkg::q60_t'(pos_q);
			end
			tsg_pkg::OP_MOD: begin
				div_start = 1'b1;
				div_dvd   = prod[tsg_pkg::PROD_W-1:0];
				div_iters = tsg_pkg::div_cnt_t'(tsg_pkg::PROD_W);
			end
			tsg_pkg::OP_ANGLE: begin
				div_start = 1'b1;
				div_init  = div_rem;
				div_iters = tsg_pkg::div_cnt_t'(tsg_pkg::ANGLE_BITS);
			end
			tsg_pkg::OP_ARG: begin
				mul_start = 1'b1;
				mul_a     = tsg_pkg::Q60_HALF_PI;
				mul_b     = x_scaled;
			end
			tsg_pkg::OP_SQUARE: begin
				mul_start = 1'b1;
				mul_a     = q60;
				mul_b     = q60;
			end
			tsg_pkg::OP_TERM_FIRST: begin
				mul_start = 1'b1;
				mul_a     = term_q;
				mul_b     = q60;
			end
			tsg_pkg::OP_RECIP: begin
				mul_start = 1'b1;
				mul_a     = q60;
				mul_b     = tsg_pkg::term_recip(k_q);
			end
			tsg_pkg::OP_QD: begin
				mul_start = 1'b1;
				mul_a     = tsg_pkg::q60_t'(prod[tsg_pkg::PW-1:66]);
				mul_b     = tsg_pkg::q60_t'(tsg_pkg::term_div(k_q));
			end
			tsg_pkg::OP_ACC: begin
				mul_start = !last_term;
				mul_a     = term_q;
				mul_b     = x2_q;
			end
			tsg_pkg::OP_SCALE: begin
				mul_start = 1'b1;
				mul_a     = sum_q;
				mul_b     = tsg_pkg::SCALE_MAX;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// Configuration, position and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q      <= tsg_pkg::FREQ_W'(1000);
			rate_q      <= tsg_pkg::RATE_W'(44100);
			total_q     <= tsg_pkg::TOTAL_W'(44100);
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tsg_pkg::CFG_FREQ:  freq_q  <= cfg_wdata[tsg_pkg::FREQ_W-1:0];
					tsg_pkg::CFG_RATE:  rate_q  <= cfg_wdata[tsg_pkg::RATE_W-1:0];
					tsg_pkg::CFG_TOTAL: total_q <= cfg_wdata[tsg_pkg::TOTAL_W-1:0];
					default: begin
					end
				endcase
			end
			if (op == tsg_pkg::OP_SEEK && !reject) begin
				pos_q <= target[tsg_pkg::POS_W-1:0];
			end else if (op == tsg_pkg::OP_FINISH) begin
				pos_q <= pos_q + tsg_pkg::pos_t'(1);
			end
			if (op == tsg_pkg::OP_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, working and result registers.
	always_ff @(posedge clk) begin
		case (op)
			tsg_pkg::OP_LATCH: begin
				cmd_q <= tsg_pkg::cmd_t'(in_cmd);
				off_q <= in_offset;
			end
			tsg_pkg::OP_SEEK: begin
				res_sample_q <= '0;
				res_status_q <= reject ? tsg_pkg::STATUS_SEEK_REJECT
				                       : tsg_pkg::STATUS_SEEK_DONE;
			end
			tsg_pkg::OP_END: begin
				res_sample_q <= '0;
				res_status_q <= tsg_pkg::STATUS_END;
			end
			tsg_pkg::OP_TAKE_ANGLE: begin
				angle_q <= div_quo;
			end
			tsg_pkg::OP_ZERO_ANGLE: begin
				angle_q <= '0;
			end
			tsg_pkg::OP_SQUARE: begin
				term_q <= q60;
				sum_q  <= q60;
			end
			tsg_pkg::OP_TERM_FIRST: begin
				x2_q <= q60;
				k_q  <= tsg_pkg::k_t'(1);
			end
			tsg_pkg::OP_RECIP: begin
				t_q <= q60;
			end
			tsg_pkg::OP_QD: begin
				q_q <= prod[tsg_pkg::PW-1:66];
			end
			tsg_pkg::OP_CORR: begin
				term_q <= term_fixed;
			end
			tsg_pkg::OP_ACC: begin
				// Odd terms of the series are subtracted, even ones added.
				sum_q <= k_q[0] ? (sum_q - term_q) : (sum_q + term_q);
				k_q   <= k_q + tsg_pkg::k_t'(1);
			end
			tsg_pkg::OP_FINISH: begin
				res_sample_q <= sample_val;
				res_status_q <= tsg_pkg::STATUS_SAMPLE;
			end
			tsg_pkg::OP_PUSH: begin
				out_sample_q <= res_sample_q;
				out_status_q <= res_status_q;
				out_pos_q    <= tsg_pkg::pos_out_t'(pos_q);
			end
			default: begin
			end
		endcase
	end

	// Status towards the controller.
	always_comb begin
		status.is_read   = (cmd_q == tsg_pkg::CMD_READ);
		status.at_end    = (tsg_pkg::end_t'(pos_q) >= end_w);
		status.rate_zero = (rate_q == '0);
		status.mul_done  = mul_done;
		status.div_done  = div_done;
		status.last_term = last_term;
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign out_sample   = out_sample_q;
	assign out_status   = out_status_q;
	assign out_position = out_pos_q;

endmodule
`default_nettype wire

FILE: design/tsg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tone sample generator controller
// Sequences one item at a time through decode, phase division, the Taylor
// series and output, issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
module tsg_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire tsg_pkg::dp_status_t st,
	output logic                     in_ready,
	output tsg_pkg::dp_op_t          op
);

	tsg_pkg::state_t state_q;
	tsg_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsg_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tsg_pkg::S_IDLE: begin
				if (in_valid) state_d = tsg_pkg::S_DECODE;
			end
			tsg_pkg::S_DECODE: begin
				if (!st.is_read || st.at_end) begin
					state_d = tsg_pkg::S_PUSH;
				end else if (st.rate_zero) begin
					state_d = tsg_pkg::S_ARG;
				end else begin
					state_d = tsg_pkg::S_WAIT_FP;
				end
			end
			tsg_pkg::S_WAIT_FP: begin
				if (st.mul_done) state_d = tsg_pkg::S_WAIT_MOD;
			end
			tsg_pkg::S_WAIT_MOD: begin
				if (st.div_done) state_d = tsg_pkg::S_WAIT_ANG;
			end
			tsg_pkg::S_WAIT_ANG: begin
				if (st.div_done) state_d = tsg_pkg::S_ARG;
			end
			tsg_pkg::S_ARG: begin
				state_d = tsg_pkg::S_WAIT_ARG;
			end
			tsg_pkg::S_WAIT_ARG: begin
				if (st.mul_done) state_d = tsg_pkg::S_WAIT_SQ;
			end
			tsg_pkg::S_WAIT_SQ: begin
				if (st.mul_done) state_d = tsg_pkg::S_WAIT_TM;
			end
			tsg_pkg::S_WAIT_TM: begin
				if (st.mul_done) state_d = tsg_pkg::S_WAIT_RC;
			end
			tsg_pkg::S_WAIT_RC: begin
				if (st.mul_done) state_d = tsg_pkg::S_WAIT_QD;
			end
			tsg_pkg::S_WAIT_QD: begin
				if (st.mul_done) state_d = tsg_pkg::S_ACC;
			end
			tsg_pkg::S_ACC: begin
				state_d = st.last_term ? tsg_pkg::S_SCALE : tsg_pkg::S_WAIT_TM;
			end
			tsg_pkg::S_SCALE: begin
				state_d = tsg_pkg::S_WAIT_SC;
			end
			tsg_pkg::S_WAIT_SC: begin
				if (st.mul_done) state_d = tsg_pkg::S_PUSH;
			end
			tsg_pkg::S_PUSH: begin
				if (st.out_free) state_d = tsg_pkg::S_IDLE;
			end
			default: begin
				state_d = tsg_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs: the datapath operation of this cycle and input ready.
	always_comb begin
		op       = tsg_pkg::OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			tsg_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) op = tsg_pkg::OP_LATCH;
			end
			tsg_pkg::S_DECODE: begin
				if (!st.is_read) begin
					op = tsg_pkg::OP_SEEK;
				end else if (st.at_end) begin
					op = tsg_pkg::OP_END;
				end else if (st.rate_zero) begin
					op = tsg_pkg::OP_ZERO_ANGLE;
				end else begin
					op = tsg_pkg::OP_MUL_FP;
				end
			end
			tsg_pkg::S_WAIT_FP: begin
				if (st.mul_done) op = tsg_pkg::OP_MOD;
			end
			tsg_pkg::S_WAIT_MOD: begin
				if (st.div_done) op = tsg_pkg::OP_ANGLE;
			end
			tsg_pkg::S_WAIT_ANG: begin
				if (st.div_done) op = tsg_pkg::OP_TAKE_ANGLE;
			end
			tsg_pkg::S_ARG: begin
				op = tsg_pkg::OP_ARG;
			end
			tsg_pkg::S_WAIT_ARG: begin
				if (st.mul_done) op = tsg_pkg::OP_SQUARE;
			end
			tsg_pkg::S_WAIT_SQ: begin
				if (st.mul_done) op = tsg_pkg::OP_TERM_FIRST;
			end
			tsg_pkg::S_WAIT_TM: begin
				if (st.mul_done) op = tsg_pkg::OP_RECIP;
			end
			tsg_pkg::S_WAIT_RC: begin
				if (st.mul_done) op = tsg_pkg::OP_QD;
			end
			tsg_pkg::S_WAIT_QD: begin
				if (st.mul_done) op = tsg_pkg::OP_CORR;
			end
			tsg_pkg::S_ACC: begin
				op = tsg_pkg::OP_ACC;
			end
			tsg_pkg::S_SCALE: begin
				op = tsg_pkg::OP_SCALE;
			end
			tsg_pkg::S_WAIT_SC: begin
				if (st.mul_done) op = tsg_pkg::OP_FINISH;
			end
			tsg_pkg::S_PUSH: begin
				if (st.out_free) op = tsg_pkg::OP_PUSH;
			end
			default: begin
				op = tsg_pkg::OP_NONE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: design/tone_sample_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tone sample generator
// Bounded-length sine tone source with sample-accurate seeking.
// A seek or end-of-tone word has its result registered at decode and then moves
// to the output register; a sample read spends most of its time in the serial
// divider (skipped with a zero sample rate) and in the Taylor series products
// on the shared multiplier. One word at a time: the next is taken the cycle
// after the result is queued. Reset clears the position.
// ----------------------------------------------------------------------------
module tone_sample_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input word stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] offset
	input  wire logic [1:0]  s_tuser,   // [1:0] cmd
	// Result word stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [15:0] sample, [46:16] position, [47] zero
	output logic [1:0]       m_tuser,   // [1:0] status
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [30:0] cfg_wdata
);

	tsg_pkg::dp_op_t                  op;
	tsg_pkg::dp_status_t              st;
	logic [tsg_pkg::SAMPLE_W-1:0]     sample;
	logic [tsg_pkg::STATUS_W-1:0]     status;
	logic [tsg_pkg::POS_OUT_W-1:0]    position;

	// Controller.
	tsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.st       (st),
		.in_ready (s_tready),
		.op       (op)
	);

	// Datapath.
	tsg_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.in_cmd       (s_tuser),
		.in_offset    (s_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.out_ready    (m_tready),
		.status       (st),
		.out_valid    (m_tvalid),
		.out_sample   (sample),
		.out_status   (status),
		.out_position (position)
	);

	// Result word packing.
	assign m_tdata = {1'b0, position, sample};
	assign m_tuser = status;

endmodule
`default_nettype wire
